>>> hw/rtl/crf_pkg.sv
// Shared types and constants for the capture record framer.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package crf_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int SNAP_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_MGMT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_DATA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_CTRL = 2'd2;

  localparam logic [SNAP_W-1:0] SNAP_MGMT_RST = 12'd256;
  localparam logic [SNAP_W-1:0] SNAP_DATA_RST = 12'd64;
  localparam logic [SNAP_W-1:0] SNAP_CTRL_RST = 12'd32;

  // Frame commands
  localparam logic [1:0] CMD_GOOD = 2'd0;
  localparam logic [1:0] CMD_FAIL = 2'd1;
  localparam logic [1:0] CMD_BYTE = 2'd2;

  // Frame types
  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_DATA = 2'd2;

  // Record framing
  localparam logic [7:0]        SYNC0        = 8'hA5;
  localparam logic [7:0]        SYNC1        = 8'h5A;
  localparam logic [7:0]        REC_TYPE     = 8'h02;
  localparam logic [7:0]        REC_PAD      = 8'h00;
  localparam logic [SNAP_W-1:0] FCS_BYTES    = 12'd4;
  localparam logic [15:0]       BODY_FIXED   = 16'd18;
  localparam logic [8:0]        FLETCHER_MOD = 9'd255;

  typedef enum logic {
    JOB_START,
    JOB_BYTE
  } job_kind_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [11:0]       sig_len;
    logic [31:0]       rx_timestamp;
    logic signed [7:0] rssi;
    logic [7:0]        rate;
    logic [7:0]        phy_mode;
    logic [7:0]        mcs;
    logic [2:0]        phy_flags;
    logic [7:0]        channel;
    logic [1:0]        frame_kind;
    logic signed [7:0] noise_dbm;
    logic [7:0]        payload_byte;
  } frame_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        record_end;
    logic [31:0] seen_count;
    logic [31:0] queued_count;
    logic [31:0] bad_frame_count;
  } rec_t;

  // One queued unit of work: a record header or one payload byte
  typedef struct packed {
    job_kind_t   kind;
    logic        close;
    logic [7:0]  data;
    logic [15:0] rec_len;
    logic [31:0] seq;
    logic [31:0] timestamp;
    logic [7:0]  rssi;
    logic [7:0]  rate;
    logic [7:0]  phy_mode;
    logic [7:0]  mcs;
    logic [2:0]  flags;
    logic [7:0]  channel;
    logic [1:0]  frame_kind;
    logic [15:0] frame_len;
    logic [7:0]  noise;
    logic [31:0] seen;
    logic [31:0] queued;
    logic [31:0] bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/crf_front.sv
// Front end: accepts frame words, keeps the counters and snap registers,
// tracks the open record and queues header and byte jobs. Uses crf_pkg.
`default_nettype none

module crf_front #(
  parameter int COUNTER_BITS = crf_pkg::COUNTER_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire logic [crf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crf_pkg::SNAP_W-1:0]    cfg_data,
  input  wire                               frame_valid,
  input  wire crf_pkg::frame_t              frame,
  output logic                              frame_stall,
  output logic                              push,
  output crf_pkg::job_t                     job,
  input  wire crf_pkg::q_status_t           q_status
);

  localparam int LOW_W = (COUNTER_BITS < 32) ? COUNTER_BITS : 32;

  logic [crf_pkg::SNAP_W-1:0] keep_mgmt;
  logic [crf_pkg::SNAP_W-1:0] keep_data;
  logic [crf_pkg::SNAP_W-1:0] keep_ctrl;

  logic                       record_open, record_open_next;
  logic [crf_pkg::SNAP_W-1:0] bytes_to_capture, bytes_to_capture_next;
  logic [COUNTER_BITS-1:0]    seen_total, seen_total_next;
  logic [COUNTER_BITS-1:0]    queued_total, queued_total_next;
  logic [COUNTER_BITS-1:0]    bad_total, bad_total_next;

  logic                       accept;
  logic [crf_pkg::SNAP_W-1:0] orig;
  logic [crf_pkg::SNAP_W-1:0] snap;
  logic [crf_pkg::SNAP_W-1:0] cap;

  assign frame_stall = q_status.full;
  assign accept      = frame_valid && !q_status.full;

  always_comb begin
    if (frame.sig_len >= crf_pkg::FCS_BYTES) begin
      orig = frame.sig_len - crf_pkg::FCS_BYTES;
    end else begin
      orig = frame.sig_len;
    end
    if (frame.frame_kind == crf_pkg::TYPE_MGMT) begin
      snap = keep_mgmt;
    end else if (frame.frame_kind == crf_pkg::TYPE_DATA) begin
      snap = keep_data;
    end else begin
      snap = keep_ctrl;
    end
    cap = (orig < snap) ? orig : snap;
  end

  always_comb begin
    record_open_next      = record_open;
    bytes_to_capture_next = bytes_to_capture;
    seen_total_next       = seen_total;
    queued_total_next     = queued_total;
    bad_total_next        = bad_total;
    push                  = 1'b0;
    job.kind              = crf_pkg::JOB_BYTE;
    job.close             = 1'b0;
    if (accept) begin
      case (frame.command)
        crf_pkg::CMD_GOOD: begin
          seen_total_next       = seen_total + 1'b1;
          queued_total_next     = queued_total + 1'b1;
          push                  = 1'b1;
          job.kind              = crf_pkg::JOB_START;
          job.close             = (cap == '0);
          record_open_next      = (cap != '0);
          bytes_to_capture_next = cap;
        end
        crf_pkg::CMD_FAIL: begin
          seen_total_next = seen_total + 1'b1;
          bad_total_next  = bad_total + 1'b1;
        end
        crf_pkg::CMD_BYTE: begin
          if (record_open) begin
            push                  = 1'b1;
            job.close             = (bytes_to_capture == crf_pkg::SNAP_W'(1));
            bytes_to_capture_next = bytes_to_capture - 1'b1;
            record_open_next      = (bytes_to_capture != crf_pkg::SNAP_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
    job.data       = frame.payload_byte;
    job.rec_len    = 16'(cap) + crf_pkg::BODY_FIXED;
    job.seq        = 32'(queued_total[LOW_W-1:0]);
    job.timestamp  = frame.rx_timestamp;
    job.rssi       = frame.rssi;
    job.rate       = frame.rate;
    job.phy_mode   = frame.phy_mode;
    job.mcs        = frame.mcs;
    job.flags      = frame.phy_flags;
    job.channel    = frame.channel;
    job.frame_kind = frame.frame_kind;
    job.frame_len  = 16'(orig);
    job.noise      = frame.noise_dbm;
    job.seen       = 32'(seen_total_next[LOW_W-1:0]);
    job.queued     = 32'(queued_total_next[LOW_W-1:0]);
    job.bad        = 32'(bad_total_next[LOW_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mgmt        <= crf_pkg::SNAP_MGMT_RST;
      keep_data        <= crf_pkg::SNAP_DATA_RST;
      keep_ctrl        <= crf_pkg::SNAP_CTRL_RST;
      record_open      <= 1'b0;
      bytes_to_capture <= '0;
      seen_total       <= '0;
      queued_total     <= '0;
      bad_total        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crf_pkg::REG_SNAP_MGMT: keep_mgmt <= cfg_data;
          crf_pkg::REG_SNAP_DATA: keep_data <= cfg_data;
          crf_pkg::REG_SNAP_CTRL: keep_ctrl <= cfg_data;
          default: begin
          end
        endcase
      end
      record_open      <= record_open_next;
      bytes_to_capture <= bytes_to_capture_next;
      seen_total       <= seen_total_next;
      queued_total     <= queued_total_next;
      bad_total        <= bad_total_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/crf_queue.sv
// Short job queue between the front end and the record emitter.
// Holds crf_pkg::job_t entries in flops; uses crf_pkg.
`default_nettype none

module crf_queue #(
  parameter int DEPTH = crf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  wire crf_pkg::job_t      push_job,
  input  wire                     pop,
  output crf_pkg::job_t           head,
  output crf_pkg::q_status_t      q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crf_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/crf_back.sv
// Record emitter: walks each queued job one byte per unstalled cycle, folds the
// Fletcher-16 sums and drives the registered record output. Uses crf_pkg.
`default_nettype none

module crf_back (
  input  wire                     clk,
  input  wire                     rst,
  input  wire crf_pkg::job_t      head,
  input  wire crf_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    rec_valid,
  output crf_pkg::rec_t           rec,
  input  wire                     rec_stall
);

  localparam logic [4:0] POS_FIRST_FOLD = 5'd2;
  localparam logic [4:0] POS_LAST_HDR   = 5'd23;
  localparam logic [4:0] POS_SUM_LO     = 5'd24;
  localparam logic [4:0] POS_SUM_HI     = 5'd25;

  logic [4:0] pos, pos_next;
  logic [7:0] sum_low, sum_low_next;
  logic [7:0] sum_high, sum_high_next;
  logic       emit;
  logic       fold;
  logic       last_data;
  logic       done;
  logic [7:0] byte_sel;

  function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= crf_pkg::FLETCHER_MOD) begin
      s = s - crf_pkg::FLETCHER_MOD;
    end
    return s[7:0];
  endfunction

  assign emit = !q_status.empty && (!rec_valid || !rec_stall);

  always_comb begin
    case (pos)
      5'd0:    byte_sel = (head.kind == crf_pkg::JOB_START) ? crf_pkg::SYNC0 : head.data;
      5'd1:    byte_sel = crf_pkg::SYNC1;
      5'd2:    byte_sel = crf_pkg::REC_TYPE;
      5'd3:    byte_sel = crf_pkg::REC_PAD;
      5'd4:    byte_sel = head.rec_len[7:0];
      5'd5:    byte_sel = head.rec_len[15:8];
      5'd6:    byte_sel = head.seq[7:0];
      5'd7:    byte_sel = head.seq[15:8];
      5'd8:    byte_sel = head.seq[23:16];
      5'd9:    byte_sel = head.seq[31:24];
      5'd10:   byte_sel = head.timestamp[7:0];
      5'd11:   byte_sel = head.timestamp[15:8];
      5'd12:   byte_sel = head.timestamp[23:16];
      5'd13:   byte_sel = head.timestamp[31:24];
      5'd14:   byte_sel = head.rssi;
      5'd15:   byte_sel = head.rate;
      5'd16:   byte_sel = head.phy_mode;
      5'd17:   byte_sel = head.mcs;
      5'd18:   byte_sel = {5'b0, head.flags};
      5'd19:   byte_sel = head.channel;
      5'd20:   byte_sel = {6'b0, head.frame_kind};
      5'd21:   byte_sel = head.frame_len[7:0];
      5'd22:   byte_sel = head.frame_len[15:8];
      5'd23:   byte_sel = head.noise;
      5'd24:   byte_sel = sum_low;
      5'd25:   byte_sel = sum_high;
      default: byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    fold      = (head.kind == crf_pkg::JOB_START)
                ? (pos >= POS_FIRST_FOLD && pos <= POS_LAST_HDR)
                : (pos == '0);
    last_data = (head.kind == crf_pkg::JOB_START) ? (pos == POS_LAST_HDR) : (pos == '0);
    done      = (last_data && !head.close) || (pos == POS_SUM_HI);
    if (done) begin
      pos_next = '0;
    end else if (last_data) begin
      pos_next = POS_SUM_LO;
    end else begin
      pos_next = pos + 1'b1;
    end
    sum_low_next  = sum_low;
    sum_high_next = sum_high;
    if (head.kind == crf_pkg::JOB_START && pos == '0) begin
      // restart sums at the head of every record
      sum_low_next  = '0;
      sum_high_next = '0;
    end else if (fold) begin
      sum_low_next  = mod_add(sum_low, byte_sel);
      sum_high_next = mod_add(sum_high, sum_low_next);
    end
  end

  assign pop = emit && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      sum_low   <= '0;
      sum_high  <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (emit) begin
        pos       <= pos_next;
        sum_low   <= sum_low_next;
        sum_high  <= sum_high_next;
        rec_valid <= 1'b1;
      end else if (!rec_stall) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rec.out_byte        <= byte_sel;
      rec.record_end      <= (pos == POS_SUM_HI);
      rec.seen_count      <= head.seen;
      rec.queued_count    <= head.queued;
      rec.bad_frame_count <= head.bad;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/capture_record_framer.sv
// Top level of the capture record framer: front end, job queue, emitter.
// Depends on crf_pkg, crf_front, crf_queue and crf_back.
//
//  channel  direction  handshake                 word
//  frame    in         frame_valid/frame_stall   crf_pkg::frame_t
//  rec      out        rec_valid/rec_stall       crf_pkg::rec_t
//  cfg      in         cfg_we (no wait)          cfg_index, cfg_data
//
// Every record byte leaves the emitter's output register, one per unstalled
// cycle. A payload byte or a good start's header is followed by the checksum
// bytes when it closes the record. A failed frame adds no record bytes.
// The job queue (QUEUE_DEPTH entries) lets frame words enter while a header
// is still going out; frame_stall rises only when that queue is full.
// Reset (rst, synchronous) restores snap defaults and clears all counters.
`default_nettype none

module capture_record_framer #(
  parameter int COUNTER_BITS = crf_pkg::COUNTER_BITS_DEF,
  parameter int QUEUE_DEPTH  = crf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire logic [crf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crf_pkg::SNAP_W-1:0]    cfg_data,
  input  wire                                frame_valid,
  input  wire crf_pkg::frame_t               frame,
  output logic                               frame_stall,
  output logic                               rec_valid,
  output crf_pkg::rec_t                      rec,
  input  wire                                rec_stall
);

  logic               push;
  logic               pop;
  crf_pkg::job_t      job;
  crf_pkg::job_t      head;
  crf_pkg::q_status_t q_status;

  crf_front #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .frame_valid(frame_valid),
    .frame      (frame),
    .frame_stall(frame_stall),
    .push       (push),
    .job        (job),
    .q_status   (q_status)
  );

  crf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(job),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  crf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .rec_valid(rec_valid),
    .rec      (rec),
    .rec_stall(rec_stall)
  );

`ifndef ASSERT_OFF
  a_good_start_queues: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_stall && frame.command == crf_pkg::CMD_GOOD) |=> !q_status.empty)
    else $error("good start did not reach the job queue");

  a_failed_frame_no_job: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_stall && frame.command == crf_pkg::CMD_FAIL && q_status.empty)
    |=> q_status.empty)
    else $error("failed frame produced a job");

  a_emitter_busy: assert property (@(posedge clk) disable iff (rst)
    (!q_status.empty && !rec_valid) |=> rec_valid)
    else $error("emitter idle with work queued");
`endif

endmodule

`default_nettype wire
